// ===== hw/rtl/koc_pkg.sv =====
// Shared constants, types and the key normalization function of the key occurrence counter.
package koc_pkg;

    localparam int KEY_W     = 64;
    localparam int KEY_BYTES = KEY_W / 8;
    localparam int SLOT_W    = 4;
    localparam int OCC_W     = 16;
    localparam int TOTAL_W   = 5;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    localparam int ENTRIES_DEF     = 16;
    localparam int KEY_CHARS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic update;
        logic any_hit;
    } cell_ctrl_t;

    // Status that a cell reports back to the top level and its right neighbor.
    typedef struct packed {
        logic hit;
        logic valid;
    } cell_status_t;

    // Keep the top chars bytes of the name, stopping at the first zero byte.
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw,
                                                       input int chars);
        logic [KEY_W-1:0] res;
        logic             alive;
        res   = '0;
        alive = 1'b1;
        for (int p = 0; p < KEY_BYTES; p++)
        begin
            if (p >= chars)
            begin
                alive = 1'b0;
            end
            if (raw[KEY_W-1-8*p -: 8] == 8'h00)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                res[KEY_W-1-8*p -: 8] = raw[KEY_W-1-8*p -: 8];
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/koc_cell.sv =====
// One table cell: holds a key, its count and a valid bit, and compares the broadcast key.
module koc_cell #(
    parameter int COUNT_WIDTH = koc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [koc_pkg::KEY_W-1:0] key,
    input  koc_pkg::cell_ctrl_t       ctrl,
    input  logic                      prev_valid,
    output koc_pkg::cell_status_t     status,
    output logic [COUNT_WIDTH-1:0]    count_sat
);
    import koc_pkg::*;

    logic                   valid_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   hit;
    logic                   alloc;

    assign hit   = valid_reg && (key_reg == key);
    // Cells fill from the left, so the first empty cell is the one whose neighbor is full.
    assign alloc = ctrl.update && !ctrl.any_hit && !valid_reg && prev_valid;

    assign count_sat = (count_reg == {COUNT_WIDTH{1'b1}}) ? count_reg
                                                          : count_reg + COUNT_WIDTH'(1);

    assign status = '{hit: hit, valid: valid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (alloc)
        begin
            valid_reg <= 1'b1;
            count_reg <= COUNT_WIDTH'(1);
        end
        else if (ctrl.update && hit)
        begin
            count_reg <= count_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            key_reg <= key;
        end
    end

endmodule

// ===== hw/rtl/key_occurrence_counter.sv =====
// Top level of the key occurrence counter: input register, row of cells and result register.
// A key accepted into the input register moves its result to the result register once that is free.
// Throughput: one key per cycle while the master side keeps up; the table row is compared and
// updated while the key is held in the input register, so each key sees every earlier update.
// Reset: rst_n clears all cell valid bits, counts, the used-entry count and both valid flags.
// Held keys are not cleared; an empty cell never compares as a hit.
module key_occurrence_counter #(
    parameter int ENTRIES     = koc_pkg::ENTRIES_DEF,
    parameter int KEY_CHARS   = koc_pkg::KEY_CHARS_DEF,
    parameter int COUNT_WIDTH = koc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [koc_pkg::KEY_W-1:0]      s_tdata,  // [63:0] key
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [koc_pkg::OUT_DATA_W-1:0] m_tdata,  // [3:0] slot, [19:4] occurrences,
                                                     // [24:20] distinct_total, [31:25] zero
    output logic [koc_pkg::OUT_USER_W-1:0] m_tuser   // [0] is_new, [1] dropped_full
);
    import koc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]       key_reg;
    logic                   pend_reg;
    logic [USED_W-1:0]      used_reg;
    logic [USED_W-1:0]      used_next;
    logic                   m_valid_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   is_new_reg;
    logic                   is_new_next;
    logic                   drop_reg;
    logic                   drop_next;

    logic                   accept;
    logic                   finish;
    logic                   full;
    logic                   any_hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [COUNT_WIDTH-1:0] hit_cnt;
    cell_ctrl_t             ctrl;
    cell_status_t           status [ENTRIES];
    logic [COUNT_WIDTH-1:0] cell_cnt [ENTRIES];

    // The request in flight completes once the result register is free.
    assign finish   = pend_reg && (!m_valid_reg || m_tready);
    assign s_tready = !pend_reg || finish;
    assign accept   = s_tvalid && s_tready;
    assign full     = (used_reg == USED_W'(ENTRIES));

    assign ctrl = '{update: finish, any_hit: any_hit};

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic prev_valid;
            if (g == 0)
            begin : g_first
                assign prev_valid = 1'b1;
            end
            else
            begin : g_rest
                assign prev_valid = status[g-1].valid;
            end
            koc_cell #(
                .COUNT_WIDTH(COUNT_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .key       (key_reg),
                .ctrl      (ctrl),
                .prev_valid(prev_valid),
                .status    (status[g]),
                .count_sat (cell_cnt[g])
            );
        end
    endgenerate

    // Held keys are distinct, so at most one cell hits and an OR merge suffices.
    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = '0;
        hit_cnt = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (status[i].hit)
            begin
                any_hit = 1'b1;
                hit_idx = hit_idx | IDX_W'(i);
                hit_cnt = hit_cnt | cell_cnt[i];
            end
        end
    end

    always_comb
    begin
        used_next   = used_reg;
        slot_next   = '0;
        occ_next    = '0;
        is_new_next = 1'b0;
        drop_next   = 1'b0;
        priority if (any_hit)
        begin
            slot_next = SLOT_W'(hit_idx);
            occ_next  = OCC_W'(hit_cnt);
        end
        else if (!full)
        begin
            slot_next   = SLOT_W'(used_reg);
            occ_next    = OCC_W'(1);
            is_new_next = 1'b1;
            used_next   = used_reg + USED_W'(1);
        end
        else
        begin
            drop_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (finish)
            begin
                pend_reg <= 1'b0;
            end
            if (finish)
            begin
                used_reg    <= used_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= normalize_key(s_tdata, KEY_CHARS);
        end
        if (finish)
        begin
            slot_reg   <= slot_next;
            occ_reg    <= occ_next;
            is_new_reg <= is_new_next;
            drop_reg   <= drop_next;
            total_reg  <= TOTAL_W'(used_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - SLOT_W - OCC_W - TOTAL_W){1'b0}},
                       total_reg, occ_reg, slot_reg};
    assign m_tuser  = {drop_reg, is_new_reg};

endmodule
